>>> rtl/core/msid_pkg.sv
// Shared types and the pattern table for the MIPS subset decoder.
// No dependencies; imported by msid_match, msid_prio and the top level.
`timescale 1ns / 1ps

package msid_pkg;

    localparam int NUM_PATTERNS = 52;
    localparam int GROUP_SIZE   = 8;
    localparam int NUM_GROUPS   = (NUM_PATTERNS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int HIT_W        = NUM_GROUPS * GROUP_SIZE;

    localparam logic [5:0] CODE_ILLEGAL = 6'd51;
    localparam logic [5:0] CODE_SLL     = 6'd48;

    typedef struct packed {
        logic [31:0] mask;
        logic [31:0] match;
        logic [5:0]  code;
    } pattern_t;

    // Priority order: first entry that matches wins.
    localparam pattern_t PATTERNS [0:NUM_PATTERNS-1] = '{
        '{32'hFFFF_FFFF, 32'h0000_0000, 6'd48},   // all-zero word is NOP -> SLL
        '{32'hFC00_07FF, 32'h0000_0020, 6'd0},
        '{32'hFC00_07FF, 32'h0000_0021, 6'd1},
        '{32'hFC00_07FF, 32'h0000_0024, 6'd2},
        '{32'hFC00_07FF, 32'h0000_0027, 6'd3},
        '{32'hFC00_07FF, 32'h0000_0025, 6'd4},
        '{32'hFC00_07FF, 32'h0000_0004, 6'd5},
        '{32'hFC00_07FF, 32'h0000_002A, 6'd6},
        '{32'hFC00_07FF, 32'h0000_002B, 6'd7},
        '{32'hFC00_07FF, 32'h0000_0007, 6'd8},
        '{32'hFC00_07FF, 32'h0000_0006, 6'd9},
        '{32'hFC00_07FF, 32'h0000_0022, 6'd10},
        '{32'hFC00_07FF, 32'h0000_0023, 6'd11},
        '{32'hFC00_07FF, 32'h0000_0026, 6'd12},
        '{32'hFC1F_0000, 32'h0401_0000, 6'd13},
        '{32'hFC1F_0000, 32'h0411_0000, 6'd14},
        '{32'hFC1F_0000, 32'h0400_0000, 6'd15},
        '{32'hFC1F_0000, 32'h0410_0000, 6'd16},
        '{32'hFC1F_0000, 32'h1C00_0000, 6'd17},
        '{32'hFC1F_0000, 32'h1800_0000, 6'd18},
        '{32'hFC00_0000, 32'h2000_0000, 6'd19},
        '{32'hFC00_0000, 32'h2400_0000, 6'd20},
        '{32'hFC00_0000, 32'h3000_0000, 6'd21},
        '{32'hFC00_0000, 32'h3400_0000, 6'd22},
        '{32'hFC00_0000, 32'h3800_0000, 6'd23},
        '{32'hFC00_0000, 32'h2800_0000, 6'd24},
        '{32'hFC00_0000, 32'h2C00_0000, 6'd25},
        '{32'hFC00_0000, 32'h1000_0000, 6'd26},
        '{32'hFC00_0000, 32'h1400_0000, 6'd27},
        '{32'hFC00_0000, 32'h0800_0000, 6'd28},
        '{32'hFC00_0000, 32'h0C00_0000, 6'd29},
        '{32'hFC00_003F, 32'h0000_000D, 6'd30},
        '{32'hFC00_003F, 32'h0000_000C, 6'd31},
        '{32'hFFE0_0000, 32'h4020_0000, 6'd32},
        '{32'hFC1F_07FF, 32'h0000_0009, 6'd33},
        '{32'hFC1F_FFFF, 32'h0000_0008, 6'd34},
        '{32'hFFE0_0000, 32'h3C00_0000, 6'd35},
        '{32'hFC00_0000, 32'h8C00_0000, 6'd36},
        '{32'hFC00_0000, 32'hAC00_0000, 6'd37},
        '{32'hFC00_0000, 32'hE000_0000, 6'd38},
        '{32'hFC00_0000, 32'hC000_0000, 6'd39},
        '{32'hFFE0_07FF, 32'h4000_0000, 6'd40},
        '{32'hFFE0_07FF, 32'h4080_0000, 6'd41},
        '{32'hFFFF_07FF, 32'h0000_0010, 6'd42},
        '{32'hFFFF_07FF, 32'h0000_0012, 6'd43},
        '{32'hFC1F_FFFF, 32'h0000_0011, 6'd44},
        '{32'hFC1F_FFFF, 32'h0000_0013, 6'd45},
        '{32'hFC00_FFFF, 32'h0000_0018, 6'd46},
        '{32'hFC00_FFFF, 32'h0000_0019, 6'd47},
        '{32'hFFE0_003F, 32'h0000_0000, 6'd48},
        '{32'hFFE0_003F, 32'h0000_0003, 6'd49},
        '{32'hFFE0_003F, 32'h0000_0002, 6'd50}
    };

    // Hit vector and word after the compare stage.
    typedef struct packed {
        logic             valid;
        logic [31:0]      word;
        logic [HIT_W-1:0] hits;
    } match_bus_t;

    // First hit inside one group of patterns.
    typedef struct packed {
        logic       hit;
        logic [5:0] code;
    } grp_t;

    // Finished decode leaving the priority stages.
    typedef struct packed {
        logic        valid;
        logic        legal;
        logic [5:0]  code;
        logic [31:0] word;
    } result_t;

    // Code of a table slot; padding slots past the table read as illegal.
    function automatic logic [5:0] pat_code(input int idx);
        logic [5:0] c;
        c = CODE_ILLEGAL;
        if (idx < NUM_PATTERNS)
        begin
            c = PATTERNS[idx].code;
        end
        return c;
    endfunction

endpackage

>>> rtl/core/mips_subset_instruction_decoder.sv
// Throughput: one request per cycle; busy is held low, so start may be high every cycle.
// Four register stages: input capture, parallel pattern compare, per-group priority
// (8 patterns each), final group select into the output register.
// Reset (rst_n, async, active low) clears the stage valid bits; nothing is in flight after it.
// done is a one-cycle strobe; the receiver cannot stall, so no stage ever holds.
`timescale 1ns / 1ps

module mips_subset_instruction_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] instruction_word,
    output logic        done,
    output logic [5:0]  insn_code,
    output logic        is_legal,
    output logic [4:0]  source_reg,
    output logic [4:0]  target_reg,
    output logic [4:0]  dest_reg,
    output logic [4:0]  shift_amount,
    output logic [15:0] immediate
);
    import msid_pkg::*;

    match_bus_t match_bus;
    result_t    res;
    logic       take;

    // Pipeline never back-pressures: every request is taken.
    assign busy = 1'b0;
    assign take = start & ~busy;

    // Stages 1-2: capture the word, compare against every table entry.
    msid_match u_match (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .instruction_word (instruction_word),
        .match_out        (match_bus)
    );

    // Stages 3-4: lowest-index hit wins; no hit gives the illegal code.
    msid_prio u_prio (
        .clk      (clk),
        .rst_n    (rst_n),
        .match_in (match_bus),
        .result   (res)
    );

    // Field slices ride along with the word; they are raw even for illegal words.
    assign done         = res.valid;
    assign insn_code    = res.code;
    assign is_legal     = res.legal;
    assign source_reg   = res.word[25:21];
    assign target_reg   = res.word[20:16];
    assign dest_reg     = res.word[15:11];
    assign shift_amount = res.word[10:6];
    assign immediate    = res.word[15:0];

    // Every accepted request comes out on done after passing through all stage registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##4 done)
        else $error("request did not complete in four cycles");

    // No strobe without a matching earlier request.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(take, 4))
        else $error("done without a matching request");

    // Legal flag and code agree.
    a_legal_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_legal == (insn_code != CODE_ILLEGAL)))
        else $error("is_legal disagrees with insn_code");

    // All-zero word always decodes as the shift-left code.
    a_nop_sll: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (instruction_word == 32'h0)) |-> ##4 (is_legal && (insn_code == CODE_SLL)))
        else $error("all-zero word not decoded as NOP");

endmodule

>>> rtl/core/msid_match.sv
// Input register and pattern compare stage of the decoder.
// Depends on msid_pkg (pattern table, match_bus_t).
`timescale 1ns / 1ps

module msid_match (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [31:0]         instruction_word,
    output msid_pkg::match_bus_t match_out
);
    import msid_pkg::*;

    logic                 s1_valid_reg;
    logic [31:0]          s1_word_reg;
    logic                 s2_valid_reg;
    logic [31:0]          s2_word_reg;
    logic [HIT_W-1:0]     s2_hits_reg;
    logic [HIT_W-1:0]     s2_hits_next;

    // One equality compare per table entry, all in parallel.
    always_comb
    begin
        s2_hits_next = '0;
        for (int i = 0; i < NUM_PATTERNS; i++)
        begin
            s2_hits_next[i] = ((s1_word_reg & PATTERNS[i].mask) == PATTERNS[i].match);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg <= instruction_word;
        s2_word_reg <= s1_word_reg;
        s2_hits_reg <= s2_hits_next;
    end

    assign match_out.valid = s2_valid_reg;
    assign match_out.word  = s2_word_reg;
    assign match_out.hits  = s2_hits_reg;

endmodule

>>> rtl/core/msid_prio.sv
// Two-stage priority encoder: first hit per group, then first hit group.
// Depends on msid_pkg (match_bus_t, grp_t, result_t, pat_code).
`timescale 1ns / 1ps

module msid_prio (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msid_pkg::match_bus_t match_in,
    output msid_pkg::result_t    result
);
    import msid_pkg::*;

    grp_t        s3_grp_reg  [NUM_GROUPS];
    grp_t        s3_grp_next [NUM_GROUPS];
    logic        s3_valid_reg;
    logic [31:0] s3_word_reg;

    logic        s4_valid_reg;
    logic        s4_legal_reg;
    logic        s4_legal_next;
    logic [5:0]  s4_code_reg;
    logic [5:0]  s4_code_next;
    logic [31:0] s4_word_reg;

    // Within a group, scan from the last slot down so the lowest index wins.
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            s3_grp_next[g].hit  = 1'b0;
            s3_grp_next[g].code = CODE_ILLEGAL;
            for (int j = GROUP_SIZE - 1; j >= 0; j--)
            begin
                if (match_in.hits[g * GROUP_SIZE + j])
                begin
                    s3_grp_next[g].hit  = 1'b1;
                    s3_grp_next[g].code = pat_code(g * GROUP_SIZE + j);
                end
            end
        end
    end

    always_comb
    begin
        s4_legal_next = 1'b0;
        s4_code_next  = CODE_ILLEGAL;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (s3_grp_reg[g].hit)
            begin
                s4_legal_next = 1'b1;
                s4_code_next  = s3_grp_reg[g].code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= match_in.valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_grp_reg   <= s3_grp_next;
        s3_word_reg  <= match_in.word;
        s4_legal_reg <= s4_legal_next;
        s4_code_reg  <= s4_code_next;
        s4_word_reg  <= s3_word_reg;
    end

    assign result.valid = s4_valid_reg;
    assign result.legal = s4_legal_reg;
    assign result.code  = s4_code_reg;
    assign result.word  = s4_word_reg;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for mips_subset_instruction_decoder: a priority casez decoder
// predicts each request, and every done strobe is compared field by field.
// Depends on the RTL top level and msid_pkg (for the illegal code) only.
`timescale 1ns / 1ps

module tb_top;

    import msid_pkg::*;

    // Run sizing. Worst case is one maximal idle burst per request plus
    // the pipeline; the limit sits far above that.
    localparam int RANDOM_REQUESTS = 1075;
    localparam int CALM_TAIL       = 150;   // last requests sent back to back
    localparam int DRAIN_CYCLES    = 8;     // pipeline is 4 deep
    localparam int LIMIT_CYCLES    = 200000;

    // Mask shapes: which fields a pattern pins down.
    localparam logic [31:0] OP_ONLY      = 32'hFC00_0000;
    localparam logic [31:0] OP_L11       = 32'hFC00_07FF;
    localparam logic [31:0] OP_RT        = 32'hFC1F_0000;
    localparam logic [31:0] OP_FN        = 32'hFC00_003F;
    localparam logic [31:0] OP_RS        = 32'hFFE0_0000;
    localparam logic [31:0] OP_RT_L11    = 32'hFC1F_07FF;
    localparam logic [31:0] OP_RT_RD_L11 = 32'hFC1F_FFFF;
    localparam logic [31:0] OP_RS_L11    = 32'hFFE0_07FF;
    localparam logic [31:0] OP_RS_RT_L11 = 32'hFFFF_07FF;
    localparam logic [31:0] OP_RD_L11    = 32'hFC00_FFFF;
    localparam logic [31:0] OP_RS_FN     = 32'hFFE0_003F;

    // Instruction codes as the decoder numbers them.
    typedef enum logic [5:0] {
        I_ADD = 6'd0, I_ADDU, I_AND, I_NOR, I_OR, I_SLLV, I_SLT, I_SLTU,
        I_SRAV, I_SRLV, I_SUB, I_SUBU, I_XOR,
        I_BGEZ, I_BGEZAL, I_BLTZ, I_BLTZAL, I_BGTZ, I_BLEZ,
        I_ADDI, I_ADDIU, I_ANDI, I_ORI, I_XORI, I_SLTI, I_SLTIU,
        I_BEQ, I_BNE, I_J, I_JAL, I_BREAK, I_SYSCALL,
        I_COP0_RS1, I_JALR, I_JR, I_LUI, I_LW, I_SW, I_SC, I_LL,
        I_MFC0, I_MTC0, I_MFHI, I_MFLO, I_MTHI, I_MTLO, I_MULT, I_MULTU,
        I_SLL, I_SRA, I_SRL,
        I_ILLEGAL = CODE_ILLEGAL
    } insn_t;

    // One decoded word as it should leave the block.
    typedef struct packed {
        insn_t       code;
        logic        legal;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  shamt;
        logic [15:0] imm;
    } decode_t;

    // Directed row: code typed in only where it is obvious, else predicted.
    typedef struct packed {
        logic [31:0] word;
        logic        typed;
        insn_t       code;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] instruction_word;
    logic        done;
    logic [5:0]  insn_code;
    logic        is_legal;
    logic [4:0]  source_reg;
    logic [4:0]  target_reg;
    logic [4:0]  dest_reg;
    logic [4:0]  shift_amount;
    logic [15:0] immediate;

    decode_t       pending_decodes [$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    directed_row_t directed_rows [0:24];

    mips_subset_instruction_decoder DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .instruction_word (instruction_word),
        .done             (done),
        .insn_code        (insn_code),
        .is_legal         (is_legal),
        .source_reg       (source_reg),
        .target_reg       (target_reg),
        .dest_reg         (dest_reg),
        .shift_amount     (shift_amount),
        .immediate        (immediate)
    );

    always #1 clk = ~clk;

    // Priority decode. casez takes the first matching item, which mirrors
    // the "earlier pattern wins" rule. Field layout is op|rs|rt|rd|shamt|funct.
    function automatic decode_t decode_word(input logic [31:0] w);
        decode_t d;
        priority casez (w)
            32'h0000_0000:                          d.code = I_SLL;    // NOP
            {6'h00, 15'b?, 11'h020}:                d.code = I_ADD;
            {6'h00, 15'b?, 11'h021}:                d.code = I_ADDU;
            {6'h00, 15'b?, 11'h024}:                d.code = I_AND;
            {6'h00, 15'b?, 11'h027}:                d.code = I_NOR;
            {6'h00, 15'b?, 11'h025}:                d.code = I_OR;
            {6'h00, 15'b?, 11'h004}:                d.code = I_SLLV;
            {6'h00, 15'b?, 11'h02A}:                d.code = I_SLT;
            {6'h00, 15'b?, 11'h02B}:                d.code = I_SLTU;
            {6'h00, 15'b?, 11'h007}:                d.code = I_SRAV;
            {6'h00, 15'b?, 11'h006}:                d.code = I_SRLV;
            {6'h00, 15'b?, 11'h022}:                d.code = I_SUB;
            {6'h00, 15'b?, 11'h023}:                d.code = I_SUBU;
            {6'h00, 15'b?, 11'h026}:                d.code = I_XOR;
            {6'h01, 5'b?, 5'h01, 16'b?}:            d.code = I_BGEZ;
            {6'h01, 5'b?, 5'h11, 16'b?}:            d.code = I_BGEZAL;
            {6'h01, 5'b?, 5'h00, 16'b?}:            d.code = I_BLTZ;
            {6'h01, 5'b?, 5'h10, 16'b?}:            d.code = I_BLTZAL;
            {6'h07, 5'b?, 5'h00, 16'b?}:            d.code = I_BGTZ;
            {6'h06, 5'b?, 5'h00, 16'b?}:            d.code = I_BLEZ;
            {6'h08, 26'b?}:                         d.code = I_ADDI;
            {6'h09, 26'b?}:                         d.code = I_ADDIU;
            {6'h0C, 26'b?}:                         d.code = I_ANDI;
            {6'h0D, 26'b?}:                         d.code = I_ORI;
            {6'h0E, 26'b?}:                         d.code = I_XORI;
            {6'h0A, 26'b?}:                         d.code = I_SLTI;
            {6'h0B, 26'b?}:                         d.code = I_SLTIU;
            {6'h04, 26'b?}:                         d.code = I_BEQ;
            {6'h05, 26'b?}:                         d.code = I_BNE;
            {6'h02, 26'b?}:                         d.code = I_J;
            {6'h03, 26'b?}:                         d.code = I_JAL;
            {6'h00, 20'b?, 6'h0D}:                  d.code = I_BREAK;   // shamt free
            {6'h00, 20'b?, 6'h0C}:                  d.code = I_SYSCALL;
            {6'h10, 5'h01, 21'b?}:                  d.code = I_COP0_RS1;
            {6'h00, 5'b?, 5'h00, 5'b?, 11'h009}:    d.code = I_JALR;
            {6'h00, 5'b?, 5'h00, 5'h00, 11'h008}:   d.code = I_JR;
            {6'h0F, 5'h00, 21'b?}:                  d.code = I_LUI;
            {6'h23, 26'b?}:                         d.code = I_LW;
            {6'h2B, 26'b?}:                         d.code = I_SW;
            {6'h38, 26'b?}:                         d.code = I_SC;
            {6'h30, 26'b?}:                         d.code = I_LL;
            {6'h10, 5'h00, 10'b?, 11'h000}:         d.code = I_MFC0;
            {6'h10, 5'h04, 10'b?, 11'h000}:         d.code = I_MTC0;
            {6'h00, 5'h00, 5'h00, 5'b?, 11'h010}:   d.code = I_MFHI;
            {6'h00, 5'h00, 5'h00, 5'b?, 11'h012}:   d.code = I_MFLO;
            {6'h00, 5'b?, 5'h00, 5'h00, 11'h011}:   d.code = I_MTHI;
            {6'h00, 5'b?, 5'h00, 5'h00, 11'h013}:   d.code = I_MTLO;
            {6'h00, 10'b?, 5'h00, 11'h018}:         d.code = I_MULT;
            {6'h00, 10'b?, 5'h00, 11'h019}:         d.code = I_MULTU;
            {6'h00, 5'h00, 15'b?, 6'h00}:           d.code = I_SLL;
            {6'h00, 5'h00, 15'b?, 6'h03}:           d.code = I_SRA;
            {6'h00, 5'h00, 15'b?, 6'h02}:           d.code = I_SRL;
            default:                                d.code = I_ILLEGAL;
        endcase
        d.legal = (d.code != I_ILLEGAL);
        d.rs    = w[25:21];
        d.rt    = w[20:16];
        d.rd    = w[15:11];
        d.shamt = w[10:6];
        d.imm   = w[15:0];
        return d;
    endfunction

    // Fixed bits of each instruction, used to build well-formed words.
    // Kept as mask/value pairs so it is independent of the casez above.
    function automatic void insn_shape(input insn_t c, output logic [31:0] pmask,
                                       output logic [31:0] pval);
        unique case (c)
            I_ADD:      {pmask, pval} = {OP_L11, 32'h0000_0020};
            I_ADDU:     {pmask, pval} = {OP_L11, 32'h0000_0021};
            I_AND:      {pmask, pval} = {OP_L11, 32'h0000_0024};
            I_NOR:      {pmask, pval} = {OP_L11, 32'h0000_0027};
            I_OR:       {pmask, pval} = {OP_L11, 32'h0000_0025};
            I_SLLV:     {pmask, pval} = {OP_L11, 32'h0000_0004};
            I_SLT:      {pmask, pval} = {OP_L11, 32'h0000_002A};
            I_SLTU:     {pmask, pval} = {OP_L11, 32'h0000_002B};
            I_SRAV:     {pmask, pval} = {OP_L11, 32'h0000_0007};
            I_SRLV:     {pmask, pval} = {OP_L11, 32'h0000_0006};
            I_SUB:      {pmask, pval} = {OP_L11, 32'h0000_0022};
            I_SUBU:     {pmask, pval} = {OP_L11, 32'h0000_0023};
            I_XOR:      {pmask, pval} = {OP_L11, 32'h0000_0026};
            I_BGEZ:     {pmask, pval} = {OP_RT, 32'h0401_0000};
            I_BGEZAL:   {pmask, pval} = {OP_RT, 32'h0411_0000};
            I_BLTZ:     {pmask, pval} = {OP_RT, 32'h0400_0000};
            I_BLTZAL:   {pmask, pval} = {OP_RT, 32'h0410_0000};
            I_BGTZ:     {pmask, pval} = {OP_RT, 32'h1C00_0000};
            I_BLEZ:     {pmask, pval} = {OP_RT, 32'h1800_0000};
            I_ADDI:     {pmask, pval} = {OP_ONLY, 32'h2000_0000};
            I_ADDIU:    {pmask, pval} = {OP_ONLY, 32'h2400_0000};
            I_ANDI:     {pmask, pval} = {OP_ONLY, 32'h3000_0000};
            I_ORI:      {pmask, pval} = {OP_ONLY, 32'h3400_0000};
            I_XORI:     {pmask, pval} = {OP_ONLY, 32'h3800_0000};
            I_SLTI:     {pmask, pval} = {OP_ONLY, 32'h2800_0000};
            I_SLTIU:    {pmask, pval} = {OP_ONLY, 32'h2C00_0000};
            I_BEQ:      {pmask, pval} = {OP_ONLY, 32'h1000_0000};
            I_BNE:      {pmask, pval} = {OP_ONLY, 32'h1400_0000};
            I_J:        {pmask, pval} = {OP_ONLY, 32'h0800_0000};
            I_JAL:      {pmask, pval} = {OP_ONLY, 32'h0C00_0000};
            I_BREAK:    {pmask, pval} = {OP_FN, 32'h0000_000D};
            I_SYSCALL:  {pmask, pval} = {OP_FN, 32'h0000_000C};
            I_COP0_RS1: {pmask, pval} = {OP_RS, 32'h4020_0000};
            I_JALR:     {pmask, pval} = {OP_RT_L11, 32'h0000_0009};
            I_JR:       {pmask, pval} = {OP_RT_RD_L11, 32'h0000_0008};
            I_LUI:      {pmask, pval} = {OP_RS, 32'h3C00_0000};
            I_LW:       {pmask, pval} = {OP_ONLY, 32'h8C00_0000};
            I_SW:       {pmask, pval} = {OP_ONLY, 32'hAC00_0000};
            I_SC:       {pmask, pval} = {OP_ONLY, 32'hE000_0000};
            I_LL:       {pmask, pval} = {OP_ONLY, 32'hC000_0000};
            I_MFC0:     {pmask, pval} = {OP_RS_L11, 32'h4000_0000};
            I_MTC0:     {pmask, pval} = {OP_RS_L11, 32'h4080_0000};
            I_MFHI:     {pmask, pval} = {OP_RS_RT_L11, 32'h0000_0010};
            I_MFLO:     {pmask, pval} = {OP_RS_RT_L11, 32'h0000_0012};
            I_MTHI:     {pmask, pval} = {OP_RT_RD_L11, 32'h0000_0011};
            I_MTLO:     {pmask, pval} = {OP_RT_RD_L11, 32'h0000_0013};
            I_MULT:     {pmask, pval} = {OP_RD_L11, 32'h0000_0018};
            I_MULTU:    {pmask, pval} = {OP_RD_L11, 32'h0000_0019};
            I_SLL:      {pmask, pval} = {OP_RS_FN, 32'h0000_0000};
            I_SRA:      {pmask, pval} = {OP_RS_FN, 32'h0000_0003};
            I_SRL:      {pmask, pval} = {OP_RS_FN, 32'h0000_0002};
            default:    {pmask, pval} = {32'h0000_0000, 32'h0000_0000};
        endcase
    endfunction

    // Random request word. The first 51 walk every instruction once; after
    // that most words are well formed with random free fields, some have one
    // bit flipped (broken encodings, often near a pattern), the rest are noise.
    function automatic logic [31:0] random_word(input int idx);
        insn_t       c;
        logic [31:0] pmask;
        logic [31:0] pval;
        logic [31:0] w;
        int          kind;
        int          flip;
        kind = (idx < 51) ? 0 : $urandom_range(0, 9);
        c    = (idx < 51) ? insn_t'(idx) : insn_t'($urandom_range(0, 50));
        insn_shape(c, pmask, pval);
        w = ($urandom & ~pmask) | pval;
        if (kind == 7)
        begin
            flip    = $urandom_range(0, 31);
            w[flip] = ~w[flip];
        end
        else if (kind >= 8)
        begin
            w = $urandom;
        end
        return w;
    endfunction

    // Optional idle burst with start low; the word bus carries junk.
    task automatic idle_gap(input bit allowed);
        int n;
        if (allowed && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 12);
            start            <= 1'b0;
            instruction_word <= $urandom;
            repeat (n) @(posedge clk);
        end
    endtask

    // Present one request and hold it until the edge that accepts it.
    // The expected decode is queued at that edge; start stays high afterward
    // so that back-to-back requests need no second assignment in the step.
    task automatic issue_word(input logic [31:0] w, input logic typed, input insn_t code);
        decode_t d;
        d = decode_word(w);
        if (typed)
        begin
            d.code  = code;
            d.legal = (code != I_ILLEGAL);
        end
        start            <= 1'b1;
        instruction_word <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_decodes.push_back(d);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Result side: outputs are sampled at the edge that ends the done cycle,
    // before the block's own updates at that edge land.
    always @(posedge clk)
    begin
        decode_t d;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_decodes.size() == 0)
            begin
                $error("done with no request outstanding (code 0x%0h)", insn_code);
                mismatch_count++;
            end
            else
            begin
                d = pending_decodes.pop_front();
                check_field("insn_code", d.code, insn_code);
                check_field("is_legal", d.legal, is_legal);
                check_field("source_reg", d.rs, source_reg);
                check_field("target_reg", d.rt, target_reg);
                check_field("dest_reg", d.rd, dest_reg);
                check_field("shift_amount", d.shamt, shift_amount);
                check_field("immediate", d.imm, immediate);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("mips_subset_instruction_decoder verification failed");
            $finish;
        end
    end

    initial
    begin
        bit idle_on;
        int i;

        // Directed rows: field extremes, the NOP word, the shamt rule for
        // R-type ALU ops versus BREAK, overlap and near-miss encodings.
        directed_rows = '{
            '{32'h0000_0000, 1'b1, I_SLL},      // all-zero word decodes as SLL
            '{32'hFFFF_FFFF, 1'b1, I_ILLEGAL},
            '{32'h03FF_F820, 1'b1, I_ADD},      // rs/rt/rd all ones
            '{32'h0000_0060, 1'b1, I_ILLEGAL},  // ADD with shamt 1 is rejected
            '{32'h03FF_FFCD, 1'b1, I_BREAK},    // BREAK ignores shamt
            '{32'h0000_000C, 1'b1, I_SYSCALL},
            '{32'h23FF_FFFF, 1'b1, I_ADDI},     // immediate all ones
            '{32'h041F_0000, 1'b1, I_ILLEGAL},  // REGIMM with unknown rt
            '{32'h1C01_0000, 1'b1, I_ILLEGAL},  // BGTZ needs rt zero
            '{32'h0000_07C0, 1'b0, I_ILLEGAL},  // SLL, shamt 31
            '{32'h0020_0000, 1'b1, I_ILLEGAL},  // SLL needs rs zero
            '{32'h3C20_0000, 1'b1, I_ILLEGAL},  // LUI needs rs zero
            '{32'h4020_0000, 1'b0, I_ILLEGAL},
            '{32'h4000_0000, 1'b0, I_ILLEGAL},
            '{32'h409F_F800, 1'b0, I_ILLEGAL},
            '{32'h4000_0001, 1'b1, I_ILLEGAL},  // COP0 move with low bits set
            '{32'h4040_0000, 1'b1, I_ILLEGAL},  // COP0 rs 2 not decoded
            '{32'h03E0_0008, 1'b0, I_ILLEGAL},
            '{32'h03E0_F809, 1'b0, I_ILLEGAL},
            '{32'h0000_F810, 1'b0, I_ILLEGAL},
            '{32'h03FF_0018, 1'b0, I_ILLEGAL},
            '{32'h001F_FFC3, 1'b0, I_ILLEGAL},
            '{32'h0BFF_FFFF, 1'b0, I_ILLEGAL},
            '{32'hFC00_0000, 1'b1, I_ILLEGAL},  // opcode all ones
            '{32'hE3FF_FFFF, 1'b0, I_ILLEGAL}
        };

        rst_n            = 1'b0;
        start            = 1'b0;
        instruction_word = 32'h0000_0000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            idle_gap(1'b1);
            issue_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].code);
        end

        // Random part: idling is switched on and off in stretches of 64
        // requests, and the tail runs at full rate.
        idle_on = 1'b1;
        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 64 == 0)
            begin
                idle_on = ($urandom_range(0, 2) != 0);
            end
            idle_gap(idle_on && i < RANDOM_REQUESTS - CALM_TAIL);
            issue_word(random_word(i), 1'b0, I_ILLEGAL);
        end
        start <= 1'b0;

        while (pending_decodes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("mips_subset_instruction_decoder verification clean");
        end
        else
        begin
            $display("mips_subset_instruction_decoder verification failed");
        end
        $finish;
    end

endmodule
